// File: hw/rtl/glpw_pkg.sv
// Shared types and constants of the grid line path walker.
package glpw_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned HEIGHT_W = 16;

  // Slave tdata layout: start_x, start_z, end_x, end_z, height (40 bits)
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_SX_LSB   = 0;
  localparam int unsigned IN_SZ_LSB   = 6;
  localparam int unsigned IN_EX_LSB   = 12;
  localparam int unsigned IN_EZ_LSB   = 18;
  localparam int unsigned IN_HT_LSB   = 24;

  // Master tdata layout: point_x, point_z, point_height, zero pad (32 bits)
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - 2 * COORD_W - HEIGHT_W;

  // Path command handed from the front end to the walker
  typedef struct packed {
    logic [COORD_W-1:0]  start_x;
    logic [COORD_W-1:0]  start_z;
    logic [STEP_W-1:0]   total_x;
    logic [STEP_W-1:0]   total_z;
    logic                neg_x;
    logic                neg_z;
    logic [HEIGHT_W-1:0] height;
  } cmd_t;

endpackage

// File: hw/rtl/grid_line_path_walker.sv
// Top level of the grid line path walker.
// The first point of a path passes through the command queue, the walker's path
// registers and the output register. A path of N points (1..63) is loaded when the
// walker is idle; it then emits one point per cycle while the receiver takes them.
// A two-entry command queue lets input beats be taken while a path is walked.
// Reset (rst_ni low, asynchronous) empties the queue and idles the walker.
module grid_line_path_walker #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: start_x[5:0], start_z[11:6], end_x[17:12], end_z[23:18], height[39:24]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [glpw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // tdata: point_x[5:0], point_z[11:6], point_height[27:12], zero[31:28]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [glpw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);

  glpw_pkg::cmd_t                front_cmd, queue_cmd;
  logic                          queue_full, queue_empty, queue_pop;
  logic [glpw_pkg::COORD_W-1:0]  pt_x, pt_z;
  logic [glpw_pkg::HEIGHT_W-1:0] pt_height;

  glpw_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_data_i (s_axis_tdata),
    .cmd_o     (front_cmd)
  );

  glpw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_data_o  (queue_cmd)
  );

  assign s_axis_tready = !queue_full;

  glpw_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (queue_empty),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_x_o      (pt_x),
    .out_z_o      (pt_z),
    .out_height_o (pt_height),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the point beat
  assign m_axis_tdata = {{glpw_pkg::OUT_PAD_W{1'b0}}, pt_height, pt_z, pt_x};

endmodule

// File: hw/rtl/glpw_front.sv
// Front end: snaps the endpoints to the even grid and sizes both axes.
module glpw_front #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic [glpw_pkg::IN_TDATA_W-1:0] in_data_i,
  output glpw_pkg::cmd_t                  cmd_o
);

  logic [COORD_BITS-1:0] x0, z0, x1, z1;
  logic [COORD_BITS-1:0] dx, dz;
  logic                  fwd_x, fwd_z;

  // Drop bits above COORD_BITS, then clear bit 0
  assign x0 = {in_data_i[glpw_pkg::IN_SX_LSB + 1 +: COORD_BITS - 1], 1'b0};
  assign z0 = {in_data_i[glpw_pkg::IN_SZ_LSB + 1 +: COORD_BITS - 1], 1'b0};
  assign x1 = {in_data_i[glpw_pkg::IN_EX_LSB + 1 +: COORD_BITS - 1], 1'b0};
  assign z1 = {in_data_i[glpw_pkg::IN_EZ_LSB + 1 +: COORD_BITS - 1], 1'b0};

  // Direction and distance per axis; an axis with no movement counts as negative
  assign fwd_x = x1 > x0;
  assign fwd_z = z1 > z0;
  assign dx    = fwd_x ? (x1 - x0) : (x0 - x1);
  assign dz    = fwd_z ? (z1 - z0) : (z0 - z1);

  always_comb begin
    cmd_o         = '0;
    cmd_o.start_x = glpw_pkg::COORD_W'(x0);
    cmd_o.start_z = glpw_pkg::COORD_W'(z0);
    cmd_o.total_x = glpw_pkg::STEP_W'(dx[COORD_BITS-1:1]);
    cmd_o.total_z = glpw_pkg::STEP_W'(dz[COORD_BITS-1:1]);
    cmd_o.neg_x   = ~fwd_x;
    cmd_o.neg_z   = ~fwd_z;
    cmd_o.height  = in_data_i[glpw_pkg::IN_HT_LSB +: glpw_pkg::HEIGHT_W];
  end

endmodule

// File: hw/rtl/glpw_fifo.sv
// Two-entry command queue between the front end and the walker.
module glpw_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  glpw_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output glpw_pkg::cmd_t pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  glpw_pkg::cmd_t     entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o     = count_q == CNT_W'(DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Fill count stays within the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("glpw_fifo: fill count above depth");

  // A push offered on a full queue waits, so a pop frees a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && do_pop && push_i |=> !full_o)
    else $error("glpw_fifo: push taken while full");

  // Pointers are equal exactly when the queue is empty or full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) == (empty_o || full_o))
    else $error("glpw_fifo: pointers disagree with fill count");

endmodule

// File: hw/rtl/glpw_walker.sv
// Back end: walks the 4-connected staircase and emits one point per cycle while the output is taken.
module glpw_walker #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_empty_i,
  input  glpw_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [glpw_pkg::COORD_W-1:0]     out_x_o,
  output logic [glpw_pkg::COORD_W-1:0]     out_z_o,
  output logic [glpw_pkg::HEIGHT_W-1:0]    out_height_o,
  output logic                             out_last_o
);

  localparam int unsigned MV_W = COORD_BITS - 1;
  // (moved+1)*total stays below 2^(MV_W) * 2^(MV_W)
  localparam int unsigned AW   = 2 * MV_W;

  logic                          active_q, active_d;
  logic [COORD_BITS-1:0]         cur_x_q, cur_x_d, cur_z_q, cur_z_d;
  logic [MV_W-1:0]               moved_x_q, moved_x_d, moved_z_q, moved_z_d;
  logic [MV_W-1:0]               total_x_q, total_z_q;
  logic                          neg_x_q, neg_z_q;
  logic [AW-1:0]                 acc_x_q, acc_x_d, acc_z_q, acc_z_d;
  logic [glpw_pkg::HEIGHT_W-1:0] height_q;
  logic                          out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]         out_x_q, out_z_q;
  logic [glpw_pkg::HEIGHT_W-1:0] out_height_q;
  logic                          out_last_q;
  logic                          ld, adv, can_x, can_z, done, step_x;

  // Load a new path only when idle; advance when the output slot frees up
  assign ld        = !active_q && !cmd_empty_i;
  assign cmd_pop_o = ld;
  assign adv       = active_q && (!out_valid_q || out_ready_i);

  assign can_x  = moved_x_q != total_x_q;
  assign can_z  = moved_z_q != total_z_q;
  assign done   = !can_x && !can_z;
  // acc_x = (moved_x+1)*total_z, acc_z = (moved_z+1)*total_x, kept by adds
  assign step_x = can_x && (!can_z || (acc_x_q <= acc_z_q));

  // Walk step
  always_comb begin
    active_d  = active_q;
    cur_x_d   = cur_x_q;
    cur_z_d   = cur_z_q;
    moved_x_d = moved_x_q;
    moved_z_d = moved_z_q;
    acc_x_d   = acc_x_q;
    acc_z_d   = acc_z_q;
    if (ld) begin
      active_d  = 1'b1;
      cur_x_d   = cmd_i.start_x[COORD_BITS-1:0];
      cur_z_d   = cmd_i.start_z[COORD_BITS-1:0];
      moved_x_d = '0;
      moved_z_d = '0;
      acc_x_d   = AW'(cmd_i.total_z[MV_W-1:0]);
      acc_z_d   = AW'(cmd_i.total_x[MV_W-1:0]);
    end else if (adv) begin
      if (done) begin
        active_d = 1'b0;
      end else if (step_x) begin
        cur_x_d   = neg_x_q ? cur_x_q - COORD_BITS'(2) : cur_x_q + COORD_BITS'(2);
        moved_x_d = moved_x_q + 1'b1;
        acc_x_d   = acc_x_q + AW'(total_z_q);
      end else begin
        cur_z_d   = neg_z_q ? cur_z_q - COORD_BITS'(2) : cur_z_q + COORD_BITS'(2);
        moved_z_d = moved_z_q + 1'b1;
        acc_z_d   = acc_z_q + AW'(total_x_q);
      end
    end
  end

  // Output slot valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk registers
  always_ff @(posedge clk_i) begin
    cur_x_q   <= cur_x_d;
    cur_z_q   <= cur_z_d;
    moved_x_q <= moved_x_d;
    moved_z_q <= moved_z_d;
    acc_x_q   <= acc_x_d;
    acc_z_q   <= acc_z_d;
    if (ld) begin
      total_x_q <= cmd_i.total_x[MV_W-1:0];
      total_z_q <= cmd_i.total_z[MV_W-1:0];
      neg_x_q   <= cmd_i.neg_x;
      neg_z_q   <= cmd_i.neg_z;
      height_q  <= cmd_i.height;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q      <= cur_x_q;
      out_z_q      <= cur_z_q;
      out_height_q <= height_q;
      out_last_q   <= done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = glpw_pkg::COORD_W'(out_x_q);
  assign out_z_o      = glpw_pkg::COORD_W'(out_z_q);
  assign out_height_o = out_height_q;
  assign out_last_o   = out_last_q;

  // Step counts never run past the path length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (moved_x_q <= total_x_q) && (moved_z_q <= total_z_q))
    else $error("glpw_walker: step count past total");

  // A loaded path starts at zero steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> active_q && moved_x_q == '0 && moved_z_q == '0)
    else $error("glpw_walker: path load failed");

  // Emitting the final point ends the walk and flags the beat as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && done |=> !active_q && out_valid_q && out_last_q)
    else $error("glpw_walker: final point handling");

endmodule

// File: tb/grid_line_path_walker_tb.sv
// Self-checking stream testbench for the grid line path walker.
module grid_line_path_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS  = 6;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES = 16;

  // One path request and one path point as the block sees them
  typedef struct packed {
    logic [glpw_pkg::COORD_W-1:0]         start_x;
    logic [glpw_pkg::COORD_W-1:0]         start_z;
    logic [glpw_pkg::COORD_W-1:0]         end_x;
    logic [glpw_pkg::COORD_W-1:0]         end_z;
    logic signed [glpw_pkg::HEIGHT_W-1:0] height;
  } path_cmd_t;

  typedef struct packed {
    logic [glpw_pkg::COORD_W-1:0]         x;
    logic [glpw_pkg::COORD_W-1:0]         z;
    logic signed [glpw_pkg::HEIGHT_W-1:0] height;
    logic                                 last;
  } grid_point_t;

  logic                             clk_i   = 1'b0;
  logic                             rst_ni  = 1'b0;
  logic                             s_valid = 1'b0;
  logic                             s_ready;
  logic [glpw_pkg::IN_TDATA_W-1:0]  s_data  = '0;
  logic                             m_valid;
  logic                             m_ready = 1'b0;
  logic [glpw_pkg::OUT_TDATA_W-1:0] m_data;
  logic                             m_last;

  path_cmd_t   cmd_pending_q[$];
  grid_point_t point_q[$];
  path_cmd_t   cur_cmd;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycle_cnt    = 0;
  int fail_cnt     = 0;
  int paths_taken  = 0;
  int points_seen  = 0;
  int longest_path = 0;
  int hold_input_stalls = 0;

  grid_line_path_walker #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tlast (m_last)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Snap a coordinate to the even grid inside the used coordinate bits
  function automatic int snap_grid(logic [glpw_pkg::COORD_W-1:0] v);
    int m;
    m = (1 << COORD_BITS) - 1;
    return (int'(v) & m) & ~1;
  endfunction

  // Walk the staircase for one request and queue every point it yields
  task automatic walk_path(input path_cmd_t c);
    int x0, z0, x1, z1, tx, tz, mx, mz, px, pz, n;
    bit nx, nz, go_x;
    grid_point_t p;
    x0 = snap_grid(c.start_x);
    z0 = snap_grid(c.start_z);
    x1 = snap_grid(c.end_x);
    z1 = snap_grid(c.end_z);
    nx = !(x1 > x0);
    nz = !(z1 > z0);
    tx = nx ? (x0 - x1) / 2 : (x1 - x0) / 2;
    tz = nz ? (z0 - z1) / 2 : (z1 - z0) / 2;
    mx = 0;
    mz = 0;
    px = x0;
    pz = z0;
    n  = 1;
    p.x      = px[glpw_pkg::COORD_W-1:0];
    p.z      = pz[glpw_pkg::COORD_W-1:0];
    p.height = c.height;
    p.last   = (tx == 0 && tz == 0);
    point_q = {point_q, p};
    while (mx < tx || mz < tz) begin
      if (mx < tx && mz < tz) go_x = (mx + 1) * tz <= (mz + 1) * tx;
      else go_x = (mx < tx);
      if (go_x) begin
        px = (nx ? px - 2 : px + 2) & 63;
        mx++;
      end else begin
        pz = (nz ? pz - 2 : pz + 2) & 63;
        mz++;
      end
      p.x    = px[glpw_pkg::COORD_W-1:0];
      p.z    = pz[glpw_pkg::COORD_W-1:0];
      p.last = (mx >= tx && mz >= tz);
      point_q = {point_q, p};
      n++;
    end
    if (n > longest_path) longest_path = n;
  endtask

  // Sender: offer queued requests, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
    end else begin
      if (s_valid && s_ready) begin
        walk_path(cur_cmd);
        paths_taken++;
      end
      if (s_valid && !s_ready && hold_left != 0) hold_input_stalls++;
      if (!s_valid || s_ready) begin
        if (cmd_pending_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          cur_cmd = cmd_pending_q.pop_front();
          s_valid <= 1'b1;
          s_data  <= {cur_cmd.height, cur_cmd.end_z, cur_cmd.end_x,
                      cur_cmd.start_z, cur_cmd.start_x};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls plus a long hold-off when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready   <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      m_ready   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  // Output check: every point beat against the oldest predicted point
  always @(posedge clk_i) begin
    grid_point_t exp_pt;
    if (rst_ni && m_valid && m_ready) begin
      points_seen++;
      if (point_q.size() == 0) begin
        $display("%0t: unexpected point beat x=%0d z=%0d h=%0d last=%0b", $time,
                 m_data[5:0], m_data[11:6], $signed(m_data[27:12]), m_last);
        fail_cnt++;
      end else begin
        exp_pt = point_q.pop_front();
        if (m_data[5:0] !== exp_pt.x) begin
          $display("%0t: point_x expected %0d actual %0d", $time, exp_pt.x, m_data[5:0]);
          fail_cnt++;
        end
        if (m_data[11:6] !== exp_pt.z) begin
          $display("%0t: point_z expected %0d actual %0d", $time, exp_pt.z, m_data[11:6]);
          fail_cnt++;
        end
        if (m_data[27:12] !== exp_pt.height) begin
          $display("%0t: point_height expected %0d actual %0d", $time, exp_pt.height,
                   $signed(m_data[27:12]));
          fail_cnt++;
        end
        if (m_data[31:28] !== '0) begin
          $display("%0t: pad bits expected 0 actual %h", $time, m_data[31:28]);
          fail_cnt++;
        end
        if (m_last !== exp_pt.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_pt.last, m_last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points still expected", cycle_cnt,
               point_q.size());
      $display("grid_line_path_walker_tb NOT OK");
      $finish;
    end
  end

  task automatic add_cmd(input int sx, input int sz, input int ex, input int ez,
                         input int h);
    path_cmd_t c;
    c.start_x = sx[glpw_pkg::COORD_W-1:0];
    c.start_z = sz[glpw_pkg::COORD_W-1:0];
    c.end_x   = ex[glpw_pkg::COORD_W-1:0];
    c.end_z   = ez[glpw_pkg::COORD_W-1:0];
    c.height  = h[glpw_pkg::HEIGHT_W-1:0];
    cmd_pending_q = {cmd_pending_q, c};
  endtask

  // Random requests: mostly long random walks, some short, degenerate or one-axis
  task automatic add_random_cmds(input int count);
    int sx, sz, ex, ez, h, kind;
    repeat (count) begin
      kind = $urandom_range(99, 0);
      sx = $urandom_range(63, 0);
      sz = $urandom_range(63, 0);
      ex = $urandom_range(63, 0);
      ez = $urandom_range(63, 0);
      h  = $urandom_range(65535, 0);
      if (kind < 15) begin
        ex = sx + $urandom_range(9, 0) - 4;
        ez = sz + $urandom_range(9, 0) - 4;
      end else if (kind < 23) begin
        ex = sx ^ $urandom_range(1, 0);
        ez = sz ^ $urandom_range(1, 0);
      end else if (kind < 27) begin
        ex = sx;
      end else if (kind < 31) begin
        ez = sz;
      end
      add_cmd(sx, sz, ex, ez, h);
    end
  endtask

  task automatic wait_drained();
    while (cmd_pending_q.size() != 0 || s_valid || point_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: degenerate paths, extremes, single-axis and mixed-direction walks
    src_idle_pct = 13;
    snk_idle_pct = 46;
    add_cmd(0, 0, 0, 0, 0);
    add_cmd(1, 1, 1, 1, 1);
    add_cmd(63, 63, 63, 63, -32768);
    add_cmd(3, 2, 2, 3, 32767);
    add_cmd(0, 0, 63, 63, 32767);
    add_cmd(63, 63, 0, 0, -1);
    add_cmd(0, 63, 63, 0, 'h0100);
    add_cmd(63, 0, 0, 63, -'h0180);
    add_cmd(0, 0, 62, 0, 'h5555);
    add_cmd(62, 0, 0, 0, 'hAAAA);
    add_cmd(0, 0, 0, 62, 'h00FF);
    add_cmd(0, 62, 0, 0, 'hFF00);
    add_cmd(1, 0, 2, 0, 7);
    add_cmd(0, 1, 0, 2, -7);
    add_cmd(0, 0, 10, 2, 'h0080);
    add_cmd(0, 0, 2, 10, -'h0080);
    add_cmd(10, 40, 50, 4, 'h1234);
    add_cmd(40, 4, 10, 50, -'h1234);
    add_cmd(0, 0, 6, 6, 'h7F00);
    add_cmd(20, 20, 14, 26, 'h0001);
    add_cmd(33, 17, 46, 41, -2);
    wait_drained();

    // Random, receiver stalling more often than the sender
    add_random_cmds(130);
    wait_drained();

    // Random, sender gapping more often than the receiver
    src_idle_pct = 46;
    snk_idle_pct = 13;
    add_random_cmds(130);
    wait_drained();

    // Random at full rate, starting with a long receiver hold-off
    src_idle_pct = 0;
    snk_idle_pct = 0;
    add_random_cmds(140);
    hold_reqs = hold_reqs + 1;
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d paths, %0d point beats, longest path %0d points",
             paths_taken, points_seen, longest_path);
    $display("input held back for %0d cycles during the long output hold-off",
             hold_input_stalls);
    if (fail_cnt == 0 && point_q.size() == 0) begin
      $display("grid_line_path_walker_tb OK");
    end else begin
      $display("%0d mismatches, %0d points never arrived", fail_cnt, point_q.size());
      $display("grid_line_path_walker_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/glpw_pkg.sv
hw/rtl/glpw_front.sv
hw/rtl/glpw_fifo.sv
hw/rtl/glpw_walker.sv
hw/rtl/grid_line_path_walker.sv
tb/grid_line_path_walker_tb.sv
